@@ rtl/fcp_pkg.sv @@
// ----------------------------------------------------------------------------
// fcp_pkg: shared types and constants of the false-color palette entry unit
// Mode and register codes, arc geometry and fixed-point reciprocals.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fcp_pkg;

  localparam int ENTRIES_DEF = 256;

  // palette modes
  localparam logic [2:0] MODE_SQUEEZE  = 3'd0;
  localparam logic [2:0] MODE_SPECTRAL = 3'd1;
  localparam logic [2:0] MODE_GRAY     = 3'd2;
  localparam logic [2:0] MODE_REV_GRAY = 3'd3;
  localparam logic [2:0] MODE_FILE     = 3'd4;

  // configuration register indexes
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_MIN  = 1'b1;

  localparam logic [2:0] MODE_RESET = MODE_SPECTRAL;
  localparam logic [7:0] MIN_RESET  = 8'd25;

  // arc geometry in Q8: half width 63, span 126
  localparam int ARC_W     = 16128;
  localparam int ARC_W2    = 260112384;
  localparam int ARC_SPAN  = 32256;
  localparam int DIST_W    = 14;
  // level^2 * 441 <= (7225 * (W^2 - d^2)) >> 16
  localparam int ARC_GAIN  = 7225;
  localparam int ROOT_GAIN = 441;

  localparam logic [7:0] GRAY_BASE = 8'd50;
  localparam int         GRAY_STEP = 205;

  // exact reciprocal of 7 for numerators below 2^19
  localparam logic [19:0] RECIP_7 = 20'(((64'd1 << 22) + 64'd6) / 64'd7);

  localparam int FRONT_STAGES = 3;
  localparam int ARC_STAGES   = 10;
  localparam int STAGES       = FRONT_STAGES + ARC_STAGES;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

`default_nettype wire

@@ rtl/false_color_palette_entry_unit.sv @@
// ----------------------------------------------------------------------------
// false_color_palette_entry_unit: one false-color palette entry per index
// Pipeline: 13 register stages between acceptance of an index and its valid result.
// Throughput: one index per cycle, set by the 13-stage pipeline and the
//   8-stage root search in each arc lane; a stalled output still takes items
//   while any stage is empty.
// Reset: clears the valid bits; mode resets to spectral, min_index to 25.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module false_color_palette_entry_unit #(
  parameter int ENTRIES = fcp_pkg::ENTRIES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       index_valid_i,
  output logic       index_ready_o,
  input  logic [7:0] index_i,
  output logic       result_valid_o,
  input  logic       result_ready_i,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o,
  output logic       written_o
);

  localparam int L  = fcp_pkg::STAGES;
  localparam int FS = fcp_pkg::FRONT_STAGES;

  logic [2:0] mode_q;
  logic [7:0] min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= fcp_pkg::MODE_RESET;
      min_q  <= fcp_pkg::MIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fcp_pkg::REG_MODE: mode_q <= cfg_data_i[2:0];
        fcp_pkg::REG_MIN:  min_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a stage advances when result_ready_i is high or it or any stage after it has a free slot
  logic [L-1:0] v_q;
  logic [L-1:0] en;

  for (genvar k = 0; k < L; k++) begin : g_ctl
    assign en[k] = result_ready_i | ~(&v_q[L-1:k]);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= (k == 0) ? index_valid_i : v_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign index_ready_o  = en[0];
  assign result_valid_o = v_q[L-1];

  fcp_pkg::rgb_t                    ramp;
  logic                             written;
  logic [2:0][fcp_pkg::DIST_W-1:0]  arc_dist;
  logic [2:0][7:0]                  level;

  fcp_front #(
    .ENTRIES (ENTRIES)
  ) u_front (
    .clk_i     (clk_i),
    .en_i      (en[FS-1:0]),
    .index_i   (index_i),
    .mode_i    (mode_q),
    .min_i     (min_q),
    .ramp_o    (ramp),
    .written_o (written),
    .dist_o    (arc_dist)
  );

  // lane 0 blue, lane 1 green, lane 2 red
  for (genvar k = 0; k < 3; k++) begin : g_lane
    fcp_arc u_arc (
      .clk_i   (clk_i),
      .en_i    (en[L-1:FS]),
      .dist_i  (arc_dist[k]),
      .level_o (level[k])
    );
  end

  typedef struct packed {
    fcp_pkg::rgb_t ramp;
    logic          written;
  } tail_t;

  tail_t line_q [FS:L-1];

  for (genvar k = FS; k < L; k++) begin : g_line
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        if (k == FS) begin
          line_q[k] <= '{ramp: ramp, written: written};
        end else begin
          line_q[k] <= line_q[(k == FS) ? FS : k-1];
        end
      end
    end
  end

  // ramp and arc levels are never both nonzero
  assign red_o     = line_q[L-1].ramp.red   | level[2];
  assign green_o   = line_q[L-1].ramp.green | level[1];
  assign blue_o    = line_q[L-1].ramp.blue  | level[0];
  assign written_o = line_q[L-1].written;

  a_untouched_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !written_o |-> red_o == 8'd0 && green_o == 8'd0 && blue_o == 8'd0)
    else $error("untouched entry carries a nonzero level");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !index_ready_o |-> (&v_q) && !result_ready_i)
    else $error("input held off while the pipeline has a free stage");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    index_valid_i && index_ready_o |=> v_q[0])
    else $error("accepted transaction missing from the first stage");

endmodule

`default_nettype wire

@@ rtl/fcp_front.sv @@
// ----------------------------------------------------------------------------
// fcp_front: ramp levels and arc distances
// Three stages: products, reciprocal divides, level and distance forming.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcp_front #(
  parameter int ENTRIES = fcp_pkg::ENTRIES_DEF
) (
  input  logic                                   clk_i,
  input  logic [fcp_pkg::FRONT_STAGES-1:0]       en_i,
  input  logic [7:0]                             index_i,
  input  logic [2:0]                             mode_i,
  input  logic [7:0]                             min_i,
  output fcp_pkg::rgb_t                          ramp_o,
  output logic                                   written_o,
  output logic [2:0][fcp_pkg::DIST_W-1:0]        dist_o
);

  localparam logic [8:0]  NVAL     = 9'(ENTRIES);
  localparam logic [8:0]  SPAN_TOP = 9'(ENTRIES + 1);
  localparam logic [27:0] RECIP_N  =
    28'(((64'd1 << 31) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES));
  localparam logic [27:0] RECIP_10N =
    28'(((64'd1 << 31) + 64'(10 * ENTRIES) - 64'd1) / 64'(10 * ENTRIES));

  // reciprocal of the span per min_index value
  logic [25:0] recip_tab [256];
  for (genvar mi = 0; mi < 256; mi++) begin : g_recip
    localparam int SPANV = (ENTRIES + 1 - mi > 0) ? ENTRIES + 1 - mi : 1;
    localparam logic [25:0] RV =
      26'(((64'd1 << 25) + 64'(SPANV) - 64'd1) / 64'(SPANV));
    assign recip_tab[mi] = RV;
  end

  // stage 1
  logic [7:0]  nmi, dif;
  logic [8:0]  n_i, gsel;
  logic [15:0] ri;
  logic [16:0] bi, mn, gy;
  logic [17:0] gsum;
  logic [18:0] gn3;
  logic        ok;

  assign nmi  = ~min_i;
  assign dif  = index_i - min_i;
  assign n_i  = NVAL - {1'b0, index_i};
  assign ok   = (index_i >= min_i) && ({1'b0, index_i} < NVAL) &&
                (mode_i <= fcp_pkg::MODE_REV_GRAY);
  assign ri   = 16'(nmi) * 16'(index_i);
  assign bi   = 17'(nmi) * 17'(n_i);
  assign mn   = 17'(min_i) * 17'(NVAL);
  assign gsum = 18'(bi) + 18'(mn);
  assign gn3  = 19'(gsum) * 19'(3);
  assign gsel = (mode_i == fcp_pkg::MODE_GRAY) ? {1'b0, dif} : n_i;
  assign gy   = 17'(gsel) * 17'(fcp_pkg::GRAY_STEP);

  logic        s1_w;
  logic [2:0]  s1_mode;
  logic [7:0]  s1_m, s1_dif;
  logic [15:0] s1_ri;
  logic [16:0] s1_bi, s1_gy;
  logic [18:0] s1_gn3;
  logic [8:0]  s1_span;
  logic [25:0] s1_rs;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_w    <= ok;
      s1_mode <= mode_i;
      s1_m    <= min_i;
      s1_dif  <= dif;
      s1_ri   <= ri;
      s1_bi   <= bi;
      s1_gn3  <= gn3;
      s1_gy   <= gy;
      s1_span <= SPAN_TOP - {1'b0, min_i};
      s1_rs   <= recip_tab[min_i];
    end
  end

  // stage 2: divides by reciprocal multiplication
  logic [46:0] p_r, p_b, p_g;
  logic [42:0] p_y;
  logic [18:0] a1, a2;
  logic [38:0] p_o1, p_o2;

  assign p_r  = 47'(s1_ri) * 47'(RECIP_N);
  assign p_b  = 47'(s1_bi) * 47'(RECIP_N);
  assign p_g  = 47'(s1_gn3) * 47'(RECIP_10N);
  assign p_y  = 43'(s1_gy) * 43'(s1_rs);
  assign a1   = (19'(s1_span) << 9) + 19'd3;
  assign a2   = (19'(s1_span) << 10) + 19'd3;
  assign p_o1 = 39'(a1) * 39'(fcp_pkg::RECIP_7);
  assign p_o2 = 39'(a2) * 39'(fcp_pkg::RECIP_7);

  logic        s2_w;
  logic [2:0]  s2_mode;
  logic [7:0]  s2_m, s2_dif, s2_qr, s2_qb, s2_qg, s2_qy;
  logic [2:0][15:0] s2_off;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s2_w      <= s1_w;
      s2_mode   <= s1_mode;
      s2_m      <= s1_m;
      s2_dif    <= s1_dif;
      s2_qr     <= p_r[38:31];
      s2_qb     <= p_b[38:31];
      s2_qg     <= p_g[38:31];
      s2_qy     <= p_y[32:25];
      s2_off[0] <= 16'd0;
      s2_off[1] <= p_o1[37:22];
      s2_off[2] <= p_o2[37:22];
    end
  end

  // stage 3: ramp levels and distances from the arc centers
  function automatic logic [7:0] sat8(input logic [8:0] v);
    return v[8] ? 8'hFF : v[7:0];
  endfunction

  fcp_pkg::rgb_t ramp;
  logic [7:0]    gray;
  logic          arc_on;

  assign gray   = fcp_pkg::GRAY_BASE + s2_qy;
  assign arc_on = s2_w && (s2_mode == fcp_pkg::MODE_SPECTRAL);

  always_comb begin
    ramp = '0;
    case (s2_mode)
      fcp_pkg::MODE_SQUEEZE: begin
        ramp.red   = sat8({1'b0, s2_m} + {1'b0, s2_qr});
        ramp.green = s2_qg;
        ramp.blue  = sat8({1'b0, s2_m} + {1'b0, s2_qb});
      end
      fcp_pkg::MODE_GRAY, fcp_pkg::MODE_REV_GRAY: begin
        ramp.red   = gray;
        ramp.green = gray;
        ramp.blue  = gray;
      end
      default: ramp = '0;
    endcase
    if (!s2_w) begin
      ramp = '0;
    end
  end

  logic [2:0][fcp_pkg::DIST_W-1:0] arc_dist;

  for (genvar k = 0; k < 3; k++) begin : g_dist
    logic signed [17:0] xq, d, ad;
    logic               in_arc;
    assign xq     = $signed({2'b00, s2_dif, 8'h00}) - $signed({2'b00, s2_off[k]});
    assign in_arc = !xq[17] && (xq[16:0] <= 17'(fcp_pkg::ARC_SPAN));
    assign d      = xq - 18'(fcp_pkg::ARC_W);
    assign ad     = d[17] ? -d : d;
    // outside the arc: full distance gives a zero level
    assign arc_dist[k] = (in_arc && arc_on) ? ad[fcp_pkg::DIST_W-1:0]
                                            : fcp_pkg::DIST_W'(fcp_pkg::ARC_W);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      ramp_o    <= ramp;
      written_o <= s2_w;
      dist_o    <= arc_dist;
    end
  end

endmodule

`default_nettype wire

@@ rtl/fcp_arc.sv @@
// ----------------------------------------------------------------------------
// fcp_arc: one arc lane
// Square of the distance, scaled chord, then an 8-stage bitwise root search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcp_arc (
  input  logic                             clk_i,
  input  logic [fcp_pkg::ARC_STAGES-1:0]   en_i,
  input  logic [fcp_pkg::DIST_W-1:0]       dist_i,
  output logic [7:0]                       level_o
);

  logic [27:0] sq_q;
  logic [27:0] chord;
  logic [40:0] scaled;
  logic [24:0] pq_q;

  assign chord  = 28'(fcp_pkg::ARC_W2) - sq_q;
  assign scaled = 41'(chord) * 41'(fcp_pkg::ARC_GAIN);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sq_q <= 28'(dist_i) * 28'(dist_i);
    end
    if (en_i[1]) begin
      pq_q <= scaled[40:16];
    end
  end

  logic [7:0]  v_q    [8];
  logic [15:0] vsq_q  [7];
  logic [24:0] lim_q  [7];
  logic [7:0]  v_in   [8];
  logic [15:0] vsq_in [8];
  logic [24:0] lim_in [8];

  assign v_in[0]   = 8'd0;
  assign vsq_in[0] = 16'd0;
  assign lim_in[0] = pq_q;

  for (genvar j = 0; j < 8; j++) begin : g_bit
    localparam int B = 7 - j;
    logic [16:0] tsq;
    logic [25:0] lhs;
    logic        take;

    if (j > 0) begin : g_link
      assign v_in[j]   = v_q[j-1];
      assign vsq_in[j] = vsq_q[j-1];
      assign lim_in[j] = lim_q[j-1];
    end

    // (v + 2^B)^2 = v^2 + v * 2^(B+1) + 2^(2B)
    assign tsq  = 17'(vsq_in[j]) + (17'(v_in[j]) << (B + 1)) + (17'd1 << (2 * B));
    assign lhs  = 26'(tsq) * 26'(fcp_pkg::ROOT_GAIN);
    assign take = lhs <= {1'b0, lim_in[j]};

    always_ff @(posedge clk_i) begin
      if (en_i[2+j]) begin
        v_q[j] <= take ? (v_in[j] | (8'd1 << B)) : v_in[j];
      end
    end

    if (j < 7) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i[2+j]) begin
          vsq_q[j] <= take ? tsq[15:0] : vsq_in[j];
          lim_q[j] <= lim_in[j];
        end
      end
    end
  end

  assign level_o = v_q[7];

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the false-color palette entry unit
// Drives palette indexes under varied mode and min_index settings, predicts
// each entry's levels and compares every result transaction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int N_ENTRIES = 256;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       written;
  } entry_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_index_i = 1'b0;
  logic [7:0] cfg_data_i = '0;
  logic       index_valid_i = 1'b0;
  logic       index_ready_o;
  logic [7:0] index_i = '0;
  logic       result_valid_o;
  logic       result_ready_i = 1'b0;
  logic [7:0] red_o, green_o, blue_o;
  logic       written_o;

  false_color_palette_entry_unit u_top (.*);

  always #5 clk_i = ~clk_i;

  logic [2:0] pal_mode = fcp_pkg::MODE_RESET;
  logic [7:0] pal_min = fcp_pkg::MIN_RESET;
  logic [7:0] pending_idx[$];
  entry_t     expected_entries[$];
  int         fail_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         quiet_cycles = 0;

  // Largest level v with v*v*W*W <= 65025*(W*W - d*d), zero off the arc.
  function automatic logic [7:0] arc_level(longint xq);
    longint d, w2, q, t;
    logic [7:0] v;
    if (xq < 0 || xq > 32256) return 8'd0;
    d = xq - 16128;
    w2 = 64'd16128 * 16128;
    q = 65025 * (w2 - d * d);
    v = 0;
    for (int b = 7; b >= 0; b--) begin
      t = longint'(v) | (longint'(1) << b);
      if (t * t * w2 <= q) v = t[7:0];
    end
    return v;
  endfunction

  function automatic longint arc_pos(longint i, longint m, longint s, longint k);
    return (i - m) * 256 - (4 * k * s * 256 + 7) / 14;
  endfunction

  function automatic logic [7:0] clip8(longint v);
    return v > 255 ? 8'd255 : v[7:0];
  endfunction

  function automatic entry_t palette_entry(logic [7:0] idx);
    entry_t e;
    longint i, m, n, s;
    e = '0;
    i = longint'(idx); m = longint'(pal_min); n = N_ENTRIES; s = n - m + 1;
    if (i >= m && i < n && pal_mode <= fcp_pkg::MODE_REV_GRAY) begin
      e.written = 1'b1;
      case (pal_mode)
        fcp_pkg::MODE_SQUEEZE: begin
          e.red   = clip8(m + ((255 - m) * i) / n);
          e.blue  = clip8(m + ((255 - m) * (n - i)) / n);
          e.green = clip8((3 * ((255 - m) * (n - i) + m * n)) / (10 * n));
        end
        fcp_pkg::MODE_SPECTRAL: begin
          e.blue  = arc_level(arc_pos(i, m, s, 0));
          e.green = arc_level(arc_pos(i, m, s, 1));
          e.red   = arc_level(arc_pos(i, m, s, 2));
        end
        fcp_pkg::MODE_GRAY: begin
          e.red = clip8(50 + ((i - m) * 205) / s);
          e.green = e.red; e.blue = e.red;
        end
        default: begin
          e.red = clip8(50 + ((n - i) * 205) / s);
          e.green = e.red; e.blue = e.red;
        end
      endcase
    end
    return e;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    fail_count++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (index_valid_i && index_ready_o) begin
      expected_entries.push_back(palette_entry(index_i));
      void'(pending_idx.pop_front());
    end
    if (!(index_valid_i && !index_ready_o)) begin
      if (pending_idx.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        index_valid_i <= 1'b1;
        index_i <= pending_idx[0];
      end else begin
        index_valid_i <= 1'b0;
      end
    end
    result_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    entry_t e;
    if (result_valid_o && result_ready_i) begin
      if (expected_entries.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = expected_entries.pop_front();
        if (red_o !== e.red) report_mismatch("red", int'(red_o), int'(e.red));
        if (green_o !== e.green) report_mismatch("green", int'(green_o), int'(e.green));
        if (blue_o !== e.blue) report_mismatch("blue", int'(blue_o), int'(e.blue));
        if (written_o !== e.written)
          report_mismatch("written", int'(written_o), int'(e.written));
      end
    end
    if ((result_valid_o && result_ready_i) || (index_valid_i && index_ready_o))
      quiet_cycles <= 0;
    else if (rst_ni && (pending_idx.size() != 0 || expected_entries.size() != 0))
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("false_color_palette_entry_unit: mismatch");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [7:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == fcp_pkg::REG_MODE) pal_mode = data[2:0];
    else pal_min = data;
  endtask

  task automatic drain;
    wait (pending_idx.size() == 0 && !index_valid_i && expected_entries.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [2:0] mode, logic [7:0] min_idx, int count);
    write_reg(fcp_pkg::REG_MODE, {5'd0, mode});
    write_reg(fcp_pkg::REG_MIN, min_idx);
    // mostly in-range indexes, some below min_index
    for (int k = 0; k < count; k++)
      pending_idx.push_back($urandom_range(3) == 0 ? 8'($urandom_range(255))
                                                   : 8'($urandom_range(255, min_idx)));
    drain();
  endtask

  initial begin
    logic [7:0] mins[5];
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: reset settings, then extremes of every mode
    foreach (mins[j]) mins[j] = '0;
    mins[1] = 8'd25; mins[2] = 8'd254; mins[3] = 8'd255; mins[4] = 8'd128;
    pending_idx.push_back(8'd0);
    pending_idx.push_back(8'd25);
    pending_idx.push_back(8'd255);
    drain();
    for (int md = 0; md < 8; md++) begin
      write_reg(fcp_pkg::REG_MODE, md[7:0]);
      write_reg(fcp_pkg::REG_MIN, (md % 2) ? 8'd255 : 8'd0);
      pending_idx.push_back(8'd0);
      pending_idx.push_back(8'd255);
      pending_idx.push_back(8'd127);
      drain();
    end
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      for (int md = 0; md < 6; md++)
        run_phase(md[2:0], mins[(md + ph) % 5], 75);
    end
    if (fail_count == 0) begin
      $display("false_color_palette_entry_unit: match");
    end else begin
      $display("false_color_palette_entry_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ false_color_palette_entry_unit.f @@
rtl/fcp_pkg.sv
rtl/fcp_front.sv
rtl/fcp_arc.sv
rtl/false_color_palette_entry_unit.sv
tb/sv/tb.sv
